[hdl/activity_selection_sorted_top_assert.svh]
// Assertion macros used by the datapath RTL file of the activity selection block.
`ifndef ACTIVITY_SELECTION_SORTED_TOP_ASSERT_SVH
`define ACTIVITY_SELECTION_SORTED_TOP_ASSERT_SVH

// Checked outside reset.
`define ACT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ACT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hdl/act_sel_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package act_sel_pkg;

    localparam int TIME_BITS      = 16;
    localparam int MAX_ACTIVITIES = 64;

    typedef struct packed {
        logic [TIME_BITS-1:0] act_start;
        logic [TIME_BITS-1:0] finish_time;
        logic                 is_final;
    } t_in;

    typedef struct packed {
        logic [TIME_BITS-1:0] chosen_start;
        logic [TIME_BITS-1:0] chosen_finish;
        logic                 end_of_run;
    } t_out;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_PUSH_ALL,
        OP_POP_RD,
        OP_POP_LD,
        OP_PIV,
        OP_RD_J,
        OP_ADV,
        OP_SW_RA,
        OP_SW_RB,
        OP_SW_WA,
        OP_SW_WB,
        OP_PUSH_L,
        OP_PUSH_R,
        OP_SC_RD0,
        OP_SC_FIRST,
        OP_SC_RD,
        OP_SC_TAKE,
        OP_SC_SKIP,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sw_fin;   // swap place with hi instead of j
        logic bump;     // advance place along with j
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_lt2;
        logic sp_zero;
        logic less;
        logic place_eq_j;
        logic j_eq_hi;
        logic place_eq_hi;
        logic scan_end;
        logic take;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[hdl/act_sel_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module act_sel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/act_sel_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module act_sel_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_final,
    input  wire act_sel_pkg::t_status i_status,
    output logic                      o_in_ready,
    output act_sel_pkg::t_cmd         o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_POP, S_POPW, S_PIVW, S_RD, S_CMP, S_NEXT,
        S_SRA, S_SRB, S_SWA, S_SWB, S_PUSHL, S_PUSHR,
        S_SCAN0, S_SCANF, S_SCRD, S_SCMP, S_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_fin, n_fin;

    always_comb begin
        n_state     = r_state;
        n_fin       = r_fin;
        o_cmd.op     = act_sel_pkg::OP_NOP;
        o_cmd.sw_fin = r_fin;
        o_cmd.bump   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_final) n_state = S_START;
            end
            S_START: begin
                if (i_status.cnt_zero) begin
                    n_state = S_IDLE;
                end else if (i_status.cnt_lt2) begin
                    n_state = S_SCAN0;
                end else begin
                    o_cmd.op = act_sel_pkg::OP_PUSH_ALL;
                    n_state  = S_POP;
                end
            end
            S_POP: begin
                if (i_status.sp_zero) begin
                    n_state = S_SCAN0;
                end else begin
                    o_cmd.op = act_sel_pkg::OP_POP_RD;
                    n_state  = S_POPW;
                end
            end
            S_POPW: begin
                o_cmd.op = act_sel_pkg::OP_POP_LD;
                n_state  = S_PIVW;
            end
            S_PIVW: begin
                o_cmd.op = act_sel_pkg::OP_PIV;
                n_state  = S_RD;
            end
            S_RD: begin
                o_cmd.op = act_sel_pkg::OP_RD_J;
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (i_status.less && !i_status.place_eq_j) begin
                    n_fin   = 1'b0;
                    n_state = S_SRA;
                end else begin
                    o_cmd.op   = act_sel_pkg::OP_ADV;
                    o_cmd.bump = i_status.less;
                    n_state    = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_status.j_eq_hi) begin
                    if (i_status.place_eq_hi) begin
                        n_state = S_PUSHL;
                    end else begin
                        n_fin   = 1'b1;
                        n_state = S_SRA;
                    end
                end else begin
                    o_cmd.op = act_sel_pkg::OP_RD_J;
                    n_state  = S_CMP;
                end
            end
            S_SRA: begin
                o_cmd.op = act_sel_pkg::OP_SW_RA;
                n_state  = S_SRB;
            end
            S_SRB: begin
                o_cmd.op = act_sel_pkg::OP_SW_RB;
                n_state  = S_SWA;
            end
            S_SWA: begin
                o_cmd.op = act_sel_pkg::OP_SW_WA;
                n_state  = S_SWB;
            end
            S_SWB: begin
                o_cmd.op = act_sel_pkg::OP_SW_WB;
                n_state  = r_fin ? S_PUSHL : S_NEXT;
            end
            S_PUSHL: begin
                o_cmd.op = act_sel_pkg::OP_PUSH_L;
                n_state  = S_PUSHR;
            end
            S_PUSHR: begin
                o_cmd.op = act_sel_pkg::OP_PUSH_R;
                n_state  = S_POP;
            end
            S_SCAN0: begin
                o_cmd.op = act_sel_pkg::OP_SC_RD0;
                n_state  = S_SCANF;
            end
            S_SCANF: begin
                o_cmd.op = act_sel_pkg::OP_SC_FIRST;
                n_state  = S_SCRD;
            end
            S_SCRD: begin
                if (i_status.scan_end) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.op = act_sel_pkg::OP_SC_RD;
                    n_state  = S_SCMP;
                end
            end
            S_SCMP: begin
                if (!i_status.take) begin
                    o_cmd.op = act_sel_pkg::OP_SC_SKIP;
                    n_state  = S_SCRD;
                end else if (i_status.out_free) begin
                    o_cmd.op = act_sel_pkg::OP_SC_TAKE;
                    n_state  = S_SCRD;
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.op = act_sel_pkg::OP_FLUSH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
        end
    end

endmodule

`default_nettype wire

[hdl/act_sel_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "activity_selection_sorted_top_assert.svh"

module act_sel_dp #(
    parameter int MAX_ACTIVITIES = act_sel_pkg::MAX_ACTIVITIES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire act_sel_pkg::t_in     i_in_data,
    input  wire act_sel_pkg::t_cmd    i_cmd,
    output act_sel_pkg::t_status      o_status,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output act_sel_pkg::t_out         o_out_data
);

    localparam int TB   = act_sel_pkg::TIME_BITS;
    localparam int EW   = 2 * TB;
    localparam int IDXW = $clog2(MAX_ACTIVITIES);
    localparam int CNTW = $clog2(MAX_ACTIVITIES + 1);
    localparam int SW   = 2 * IDXW;
    localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_ACTIVITIES);

    logic [CNTW-1:0] r_count, n_count, r_sp, n_sp, r_pos, n_pos;
    logic [IDXW-1:0] r_lo, n_lo, r_hi, n_hi, r_j, n_j, r_place, n_place;
    logic [TB-1:0]   r_pivot, n_pivot, r_last, n_last;
    logic [EW-1:0]   r_ea, n_ea, r_pend, n_pend;
    logic            r_ovalid, n_ovalid;
    act_sel_pkg::t_out r_odata, n_odata;

    logic            m_we, m_re;
    logic [IDXW-1:0] m_waddr, m_raddr;
    logic [EW-1:0]   m_wdata, m_rdata;
    logic            s_we, s_re;
    logic [IDXW-1:0] s_waddr, s_raddr;
    logic [SW-1:0]   s_wdata, s_rdata;

    logic [IDXW-1:0] w_sb;
    logic [TB-1:0]   w_rd_start, w_rd_fin;
    logic            w_out_free, w_push_l, w_push_r;
    logic [IDXW:0]   w_place_x, w_lo_x, w_hi_x;

    act_sel_ram #(.WIDTH(EW), .DEPTH(MAX_ACTIVITIES)) u_store (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    act_sel_ram #(.WIDTH(SW), .DEPTH(MAX_ACTIVITIES)) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign w_rd_fin   = m_rdata[TB-1:0];
    assign w_rd_start = m_rdata[EW-1:TB];
    assign w_sb       = i_cmd.sw_fin ? r_hi : r_j;
    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_place_x  = {1'b0, r_place};
    assign w_lo_x     = {1'b0, r_lo};
    assign w_hi_x     = {1'b0, r_hi};
    assign w_push_l   = (w_place_x > w_lo_x + (IDXW+1)'(1)) && (r_sp < MAX_CNT);
    assign w_push_r   = (w_place_x + (IDXW+1)'(1) < w_hi_x) && (r_sp < MAX_CNT);

    always_comb begin
        o_status.cnt_zero    = (r_count == '0);
        o_status.cnt_lt2     = (r_count < CNTW'(2));
        o_status.sp_zero     = (r_sp == '0);
        o_status.less        = (w_rd_fin < r_pivot);
        o_status.place_eq_j  = (r_place == r_j);
        o_status.j_eq_hi     = (r_j == r_hi);
        o_status.place_eq_hi = (r_place == r_hi);
        o_status.scan_end    = (r_pos == r_count);
        o_status.take        = (w_rd_start >= r_last);
        o_status.out_free    = w_out_free;
    end

    always_comb begin
        n_count  = r_count;
        n_sp     = r_sp;
        n_pos    = r_pos;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_j      = r_j;
        n_place  = r_place;
        n_pivot  = r_pivot;
        n_last   = r_last;
        n_ea     = r_ea;
        n_pend   = r_pend;
        n_odata  = r_odata;
        n_ovalid = i_out_ready ? 1'b0 : r_ovalid;
        m_we     = 1'b0;
        m_waddr  = r_count[IDXW-1:0];
        m_wdata  = {i_in_data.act_start, i_in_data.finish_time};
        m_re     = 1'b0;
        m_raddr  = r_j;
        s_we     = 1'b0;
        s_waddr  = r_sp[IDXW-1:0];
        s_wdata  = {r_hi, r_lo};
        s_re     = 1'b0;
        s_raddr  = IDXW'(r_sp - CNTW'(1));

        // drop loads once the store is full
        if (i_load && r_count < MAX_CNT) begin
            m_we    = 1'b1;
            n_count = r_count + CNTW'(1);
        end

        case (i_cmd.op)
            act_sel_pkg::OP_PUSH_ALL: begin
                s_we    = 1'b1;
                s_waddr = '0;
                s_wdata = {IDXW'(r_count - CNTW'(1)), {IDXW{1'b0}}};
                n_sp    = CNTW'(1);
            end
            act_sel_pkg::OP_POP_RD: begin
                s_re = 1'b1;
                n_sp = r_sp - CNTW'(1);
            end
            act_sel_pkg::OP_POP_LD: begin
                n_lo    = s_rdata[IDXW-1:0];
                n_hi    = s_rdata[SW-1:IDXW];
                m_re    = 1'b1;
                m_raddr = s_rdata[SW-1:IDXW];
            end
            act_sel_pkg::OP_PIV: begin
                n_pivot = w_rd_fin;
                n_j     = r_lo;
                n_place = r_lo;
            end
            act_sel_pkg::OP_RD_J: begin
                m_re = 1'b1;
            end
            act_sel_pkg::OP_ADV: begin
                n_j = r_j + IDXW'(1);
                if (i_cmd.bump) n_place = r_place + IDXW'(1);
            end
            act_sel_pkg::OP_SW_RA: begin
                m_re    = 1'b1;
                m_raddr = r_place;
            end
            act_sel_pkg::OP_SW_RB: begin
                n_ea    = m_rdata;
                m_re    = 1'b1;
                m_raddr = w_sb;
            end
            act_sel_pkg::OP_SW_WA: begin
                m_we    = 1'b1;
                m_waddr = r_place;
                m_wdata = m_rdata;
            end
            act_sel_pkg::OP_SW_WB: begin
                m_we    = 1'b1;
                m_waddr = w_sb;
                m_wdata = r_ea;
                if (!i_cmd.sw_fin) begin
                    n_j     = r_j + IDXW'(1);
                    n_place = r_place + IDXW'(1);
                end
            end
            act_sel_pkg::OP_PUSH_L: begin
                if (w_push_l) begin
                    s_we    = 1'b1;
                    s_wdata = {r_place - IDXW'(1), r_lo};
                    n_sp    = r_sp + CNTW'(1);
                end
            end
            act_sel_pkg::OP_PUSH_R: begin
                if (w_push_r) begin
                    s_we    = 1'b1;
                    s_wdata = {r_hi, r_place + IDXW'(1)};
                    n_sp    = r_sp + CNTW'(1);
                end
            end
            act_sel_pkg::OP_SC_RD0: begin
                m_re    = 1'b1;
                m_raddr = '0;
            end
            act_sel_pkg::OP_SC_FIRST: begin
                n_pend = m_rdata;
                n_last = w_rd_fin;
                n_pos  = CNTW'(1);
            end
            act_sel_pkg::OP_SC_RD: begin
                m_re    = 1'b1;
                m_raddr = r_pos[IDXW-1:0];
            end
            act_sel_pkg::OP_SC_SKIP: begin
                n_pos = r_pos + CNTW'(1);
            end
            act_sel_pkg::OP_SC_TAKE: begin
                // the held pick is not the last one: send it, keep the new one
                n_odata  = '{chosen_start: r_pend[EW-1:TB],
                             chosen_finish: r_pend[TB-1:0], end_of_run: 1'b0};
                n_ovalid = 1'b1;
                n_pend   = m_rdata;
                n_last   = w_rd_fin;
                n_pos    = r_pos + CNTW'(1);
            end
            act_sel_pkg::OP_FLUSH: begin
                n_odata  = '{chosen_start: r_pend[EW-1:TB],
                             chosen_finish: r_pend[TB-1:0], end_of_run: 1'b1};
                n_ovalid = 1'b1;
                n_count  = '0;
                n_pos    = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sp     <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_sp     <= n_sp;
            r_pos    <= n_pos;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_j     <= n_j;
        r_place <= n_place;
        r_pivot <= n_pivot;
        r_last  <= n_last;
        r_ea    <= n_ea;
        r_pend  <= n_pend;
        r_odata <= n_odata;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    `ACT_ASSERT(a_count_bound, r_count <= MAX_CNT, "loaded count above capacity")
    `ACT_ASSERT(a_stack_bound, r_sp <= MAX_CNT, "range stack overflow")
    `ACT_ASSERT(a_scan_bound, r_pos <= r_count, "scan position past loaded set")
    `ACT_ASSERT(a_flush_clr, (i_cmd.op == act_sel_pkg::OP_FLUSH) |=> r_count == '0, "not emptied")

endmodule

`default_nettype wire

[hdl/activity_selection_sorted_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Greedy activity selection. Activities load one transaction per cycle into a
// store memory; loads past MAX_ACTIVITIES are dropped. The transaction
// flagged is_final drops o_in_ready while the stored set is sorted by finish
// time (in-place quicksort driven by a range stack in a second memory) and
// scanned. The quicksort does O(n log n) comparisons on typical data and
// O(n^2) on sorted input; the scan then reads each stored activity in turn
// and can stall on the result side. Selected activities leave in sort order,
// the last one with end_of_run set. No clearing pass follows reset.
module activity_selection_sorted_top #(
    parameter int MAX_ACTIVITIES = act_sel_pkg::MAX_ACTIVITIES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire act_sel_pkg::t_in  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output act_sel_pkg::t_out      o_out_data
);

    act_sel_pkg::t_cmd    w_cmd;
    act_sel_pkg::t_status w_status;
    logic                 w_load;

    assign w_load = i_in_valid && o_in_ready;

    act_sel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_final    (w_load && i_in_data.is_final),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    act_sel_dp #(.MAX_ACTIVITIES(MAX_ACTIVITIES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

[tb/tb_activity_selection_sorted_top.sv]
`timescale 1ns / 1ps

module tb_activity_selection_sorted_top;

    localparam int MAX_ACT      = act_sel_pkg::MAX_ACTIVITIES;
    localparam int TBITS        = act_sel_pkg::TIME_BITS;
    localparam int STALL_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 50;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    typedef struct {
        act_sel_pkg::t_in data;
        bit               drain;
        t_idle            idle;
    } t_load;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    act_sel_pkg::t_in  i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    act_sel_pkg::t_out o_out_data;

    activity_selection_sorted_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    t_load             pending_loads[$];
    act_sel_pkg::t_out expected_choices[$];
    t_idle idle_mode = IDLE_NONE;
    int    mismatches = 0;
    int    quiet_cycles = 0;

    // predictor copy of the activity store
    logic [TBITS-1:0] start_mem[MAX_ACT];
    logic [TBITS-1:0] finish_mem[MAX_ACT];
    int               stored = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void swap_entries(int a, int b);
        logic [TBITS-1:0] t;
        t = start_mem[a];  start_mem[a]  = start_mem[b];  start_mem[b]  = t;
        t = finish_mem[a]; finish_mem[a] = finish_mem[b]; finish_mem[b] = t;
    endfunction

    function automatic void sort_by_finish(int n);
        int lo_stack[$];
        int hi_stack[$];
        int lo, hi, place;
        if (n < 2) return;
        lo_stack.push_back(0);
        hi_stack.push_back(n - 1);
        while (lo_stack.size() > 0) begin
            lo = lo_stack.pop_back();
            hi = hi_stack.pop_back();
            place = lo;
            for (int j = lo; j < hi; j++) begin
                if (finish_mem[j] < finish_mem[hi]) begin
                    swap_entries(place, j);
                    place++;
                end
            end
            swap_entries(place, hi);
            if (place > lo + 1) begin
                lo_stack.push_back(lo);
                hi_stack.push_back(place - 1);
            end
            if (place + 1 < hi) begin
                lo_stack.push_back(place + 1);
                hi_stack.push_back(hi);
            end
        end
    endfunction

    function automatic void predict_selection(act_sel_pkg::t_in item);
        logic [TBITS-1:0]  last_finish;
        act_sel_pkg::t_out choice;
        if (stored < MAX_ACT) begin
            start_mem[stored]  = item.act_start;
            finish_mem[stored] = item.finish_time;
            stored++;
        end
        if (!item.is_final || stored == 0) return;
        sort_by_finish(stored);
        for (int k = 0; k < stored; k++) begin
            if (k == 0 || start_mem[k] >= last_finish) begin
                choice.chosen_start  = start_mem[k];
                choice.chosen_finish = finish_mem[k];
                choice.end_of_run    = 1'b0;
                expected_choices.push_back(choice);
                last_finish = finish_mem[k];
            end
        end
        expected_choices[expected_choices.size() - 1].end_of_run = 1'b1;
        stored = 0;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_in_data   <= '0;
            i_out_ready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECV: i_out_ready <= ($urandom_range(99) >= 78);
                IDLE_BOTH: i_out_ready <= ($urandom_range(99) >= 7);
                default:   i_out_ready <= 1'b1;
            endcase
            if (!i_in_valid || o_in_ready) begin
                if (pending_loads.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (pending_loads[0].drain &&
                             ((i_in_valid && o_in_ready) || expected_choices.size() != 0)) begin
                    // hold off until every selection of the previous set is out
                    i_in_valid <= 1'b0;
                end else if ((pending_loads[0].idle == IDLE_SEND &&
                              $urandom_range(99) < 78) ||
                             (pending_loads[0].idle == IDLE_BOTH &&
                              $urandom_range(99) < 7)) begin
                    i_in_valid <= 1'b0;
                    idle_mode  <= pending_loads[0].idle;
                end else begin
                    t_load next_load;
                    next_load = pending_loads.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_data  <= next_load.data;
                    idle_mode  <= next_load.idle;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
            if (i_in_valid && o_in_ready)
                predict_selection(i_in_data);
            if (o_out_valid && i_out_ready) begin
                if (expected_choices.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected transaction: start=%0d finish=%0d last=%0b",
                                 o_out_data.chosen_start, o_out_data.chosen_finish,
                                 o_out_data.end_of_run);
                    mismatches++;
                end else begin
                    act_sel_pkg::t_out want;
                    want = expected_choices.pop_front();
                    if (o_out_data.chosen_start !== want.chosen_start ||
                        o_out_data.chosen_finish !== want.chosen_finish ||
                        o_out_data.end_of_run !== want.end_of_run) begin
                        if (mismatches < 10)
                            $display("mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                     want.chosen_start, want.chosen_finish,
                                     want.end_of_run, o_out_data.chosen_start,
                                     o_out_data.chosen_finish, o_out_data.end_of_run);
                        mismatches++;
                    end
                end
            end
        end
    end

    int load_total = 0;

    task automatic add_load(int s, int f, bit fin, bit drain, t_idle idle);
        t_load ld;
        ld.data.act_start   = TBITS'(s);
        ld.data.finish_time = TBITS'(f);
        ld.data.is_final    = fin;
        ld.drain            = drain;
        ld.idle             = idle;
        pending_loads.push_back(ld);
        load_total++;
    endtask

    // style: 0 clustered, 1 full random, 2 ascending finish, 3 heavy ties
    task automatic add_set(int n, int style, t_idle idle, bit drain);
        int s, f, base;
        base = $urandom_range(60000);
        for (int k = 0; k < n; k++) begin
            case (style)
                0: begin
                    s = base + $urandom_range(200);
                    f = s + $urandom_range(40);
                end
                1: begin
                    s = $urandom_range(16'hFFFF);
                    f = $urandom_range(16'hFFFF);
                end
                2: begin
                    s = k * 500 + $urandom_range(600);
                    f = k * 500 + 400;
                end
                default: begin
                    s = $urandom_range(8);
                    f = $urandom_range(3) * 4;
                end
            endcase
            add_load(s & 16'hFFFF, f & 16'hFFFF, k == n - 1, drain && k == 0, idle);
        end
    endtask

    initial begin
        t_idle phase;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;

        // single activities at the extremes
        add_load(0, 0, 1'b1, 1'b0, IDLE_NONE);
        add_load(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, IDLE_NONE);
        add_load(16'hFFFF, 0, 1'b1, 1'b0, IDLE_NONE);
        // ties in finish time
        add_load(5, 10, 1'b0, 1'b0, IDLE_NONE);
        add_load(2, 10, 1'b0, 1'b0, IDLE_NONE);
        add_load(10, 10, 1'b0, 1'b0, IDLE_NONE);
        add_load(0, 10, 1'b1, 1'b0, IDLE_NONE);
        // overlap, touching and full-range intervals
        add_load(0, 16'hFFFF, 1'b0, 1'b0, IDLE_NONE);
        add_load(3, 7, 1'b0, 1'b0, IDLE_NONE);
        add_load(7, 9, 1'b0, 1'b0, IDLE_NONE);
        add_load(1, 4, 1'b0, 1'b0, IDLE_NONE);
        add_load(9, 9, 1'b1, 1'b0, IDLE_NONE);
        // already sorted and reverse sorted
        for (int k = 0; k < 5; k++)
            add_load(k * 3, k * 3 + 2, k == 4, 1'b0, IDLE_NONE);
        for (int k = 0; k < 5; k++)
            add_load(30 - k * 6, 32 - k * 6, k == 4, 1'b0, IDLE_NONE);

        // full store, then overflow where the dropped load carries the flag
        add_set(MAX_ACT, 2, IDLE_NONE, 1'b1);
        add_set(MAX_ACT + 2, 1, IDLE_RECV, 1'b1);

        while (load_total < 330) begin
            phase = t_idle'((load_total / 40) % 4);
            add_set($urandom_range(1, 10), $urandom_range(3), phase,
                    $urandom_range(9) == 0);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_loads.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_choices.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_choices.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[activity_selection_sorted_top.f]
+incdir+hdl
hdl/act_sel_pkg.sv
hdl/act_sel_ram.sv
hdl/act_sel_ctrl.sv
hdl/act_sel_dp.sv
hdl/activity_selection_sorted_top.sv
tb/tb_activity_selection_sorted_top.sv
